### hw/rtl/lknn_pkg.sv
// Shared types and constants of the transformed-metric nearest-neighbor search.
// Used by the controller, the datapath and the top level; depends on nothing.
package lknn_pkg;

  localparam int MAX_POINTS    = 1024;
  localparam int ADDR_W        = $clog2(MAX_POINTS);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int MAX_NEIGHBORS = 16;
  localparam int SLOT_W        = $clog2(MAX_NEIGHBORS);
  localparam int FILL_W        = SLOT_W + 1;

  localparam int DIST_W = 26;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  // Arithmetic widths of the metric pipeline.
  localparam int DIFF_W = 17;
  localparam int PROD_W = 33;
  localparam int SUM_W  = 35;
  localparam int ABS_W  = 23;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int L2_W   = SQ_W + 2;
  localparam int L1_W   = ABS_W + 2;
  localparam int ROOT_W = L2_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW0       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW2       = 3'd4;

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] b;
    logic signed [15:0] a;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } point_t;

  typedef struct packed {
    logic              clear;
    logic              append;
    logic              start;
    logic              scan_vld;
    logic [ADDR_W-1:0] scan_addr;
    logic              emit_rd;
    logic [SLOT_W-1:0] emit_slot;
    logic              emit_ld;
    logic              emit_last;
    logic              load_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  point_count;
    logic              pipe_busy;
    logic [FILL_W-1:0] fill;
    logic              out_free;
  } dp_status_t;

endpackage

### hw/rtl/lknn_ifs.sv
// Handshake channels of the search block: input items, results and config writes.
// Depends on lknn_pkg for the register index and data widths.
interface lknn_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic signed [15:0] payload_a;
  logic signed [15:0] payload_b;
  logic signed [15:0] payload_c;
  modport source (output valid, kind, coord_x, coord_y, coord_z, payload_a, payload_b,
                  payload_c, input ready);
  modport sink (input valid, kind, coord_x, coord_y, coord_z, payload_a, payload_b,
                payload_c, output ready);
endinterface

interface lknn_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] near_x;
  logic signed [15:0] near_y;
  logic signed [15:0] near_z;
  logic signed [15:0] near_a;
  logic signed [15:0] near_b;
  logic signed [15:0] near_c;
  logic [25:0]        distance;
  logic               empty_res;
  logic               last;
  modport source (output valid, near_x, near_y, near_z, near_a, near_b, near_c, distance,
                  empty_res, last, input ready);
  modport sink (input valid, near_x, near_y, near_z, near_a, near_b, near_c, distance,
                empty_res, last, output ready);
endinterface

interface lknn_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lknn_pkg::CFG_IDX_W-1:0]     index;
  logic [lknn_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/lknn_ctrl.sv
// Sequencer of the search: decodes requests, scans the store and walks the result list.
// Depends on lknn_pkg for the command and status structs.
module lknn_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             in_kind,
  output logic                   in_ready,
  input  lknn_pkg::dp_status_t   status,
  output lknn_pkg::ctrl_cmd_t    cmd
);
  import lknn_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_DRAIN   = 3'd2;
  localparam logic [2:0] ST_EMIT    = 3'd3;
  localparam logic [2:0] ST_EMIT_LD = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  scan_cnt, scan_cnt_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic              accept;
  logic              is_last;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_last  = ({1'b0, slot} + FILL_W'(1)) == status.fill;

  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    slot_next     = slot;
    cmd           = '0;
    cmd.scan_addr = scan_cnt[ADDR_W-1:0];
    cmd.emit_slot = slot;
    cmd.emit_last = is_last;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_CLEAR:  cmd.clear  = 1'b1;
            KIND_APPEND: cmd.append = 1'b1;
            KIND_QUERY: begin
              cmd.start     = 1'b1;
              scan_cnt_next = '0;
              slot_next     = '0;
              if (status.point_count == '0) begin
                state_next = ST_EMPTY;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_vld = 1'b1;
        if (scan_cnt + CNT_W'(1) == status.point_count) begin
          state_next = ST_DRAIN;
        end
        scan_cnt_next = scan_cnt + CNT_W'(1);
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // The store read is issued only once the output register can take the result.
        if (status.out_free) begin
          cmd.emit_rd = 1'b1;
          state_next  = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        slot_next   = slot + SLOT_W'(1);
        state_next  = is_last ? ST_IDLE : ST_EMIT;
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          cmd.load_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      slot     <= '0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      slot     <= slot_next;
    end
  end

endmodule

### hw/rtl/lknn_dp.sv
// Datapath of the search: point store, metric pipeline with pipelined square root,
// sorted best list, configuration registers and output register. Depends on lknn_pkg.
module lknn_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lknn_pkg::ctrl_cmd_t                  cmd,
  output lknn_pkg::dp_status_t                 status,
  input  logic signed [15:0]                   coord_x,
  input  logic signed [15:0]                   coord_y,
  input  logic signed [15:0]                   coord_z,
  input  logic signed [15:0]                   payload_a,
  input  logic signed [15:0]                   payload_b,
  input  logic signed [15:0]                   payload_c,
  input  logic                                 cfg_we,
  input  logic [lknn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lknn_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output lknn_pkg::point_t                     out_point,
  output logic [lknn_pkg::DIST_W-1:0]          out_distance,
  output logic                                 out_empty,
  output logic                                 out_last
);
  import lknn_pkg::*;

  localparam int SQ_STAGES = ROOT_W;

  // Configuration.
  logic [4:0]            neighbor_count;
  logic                  norm_mode;
  logic [CFG_DATA_W-1:0] inv_row [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= 5'd1;
      norm_mode      <= 1'b0;
      inv_row[0]     <= CFG_DATA_W'(48'h0000_0000_1000);
      inv_row[1]     <= CFG_DATA_W'(48'h0000_1000_0000);
      inv_row[2]     <= CFG_DATA_W'(48'h1000_0000_0000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEIGHBOR_COUNT: neighbor_count <= cfg_data[4:0];
        CFG_NORM_MODE:      norm_mode      <= cfg_data[0];
        CFG_INV_ROW0:       inv_row[0]     <= cfg_data;
        CFG_INV_ROW1:       inv_row[1]     <= cfg_data;
        CFG_INV_ROW2:       inv_row[2]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Query state latched at the start of a query.
  logic signed [15:0] q [3];
  logic [FILL_W-1:0]  k;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q[0] <= coord_x;
      q[1] <= coord_y;
      q[2] <= coord_z;
      if (neighbor_count == '0) begin
        k <= FILL_W'(1);
      end else if (neighbor_count > 5'(MAX_NEIGHBORS)) begin
        k <= FILL_W'(MAX_NEIGHBORS);
      end else begin
        k <= FILL_W'(neighbor_count);
      end
    end
  end

  // Point store with one write and one registered read port.
  point_t            mem [MAX_POINTS];
  point_t            rd_data;
  logic [CNT_W-1:0]  point_count;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] best_idx [MAX_NEIGHBORS];
  logic [DIST_W-1:0] best_dist [MAX_NEIGHBORS];
  logic [FILL_W-1:0] fill;

  assign rd_addr = cmd.emit_rd ? best_idx[cmd.emit_slot] : cmd.scan_addr;

  always_ff @(posedge clk) begin
    if (cmd.append && point_count < CNT_W'(MAX_POINTS)) begin
      mem[point_count[ADDR_W-1:0]] <= '{c: payload_c, b: payload_b, a: payload_a,
                                        z: coord_z, y: coord_y, x: coord_x};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cmd.clear) begin
      point_count <= '0;
    end else if (cmd.append && point_count < CNT_W'(MAX_POINTS)) begin
      point_count <= point_count + CNT_W'(1);
    end
  end

  // Metric pipeline.
  logic                     p1_vld, p2_vld, p3_vld, p4_vld, p5_vld;
  logic [ADDR_W-1:0]        p1_idx, p2_idx, p3_idx, p4_idx, p5_idx;
  logic signed [DIFF_W-1:0] p2_d [3];
  logic signed [PROD_W-1:0] p3_prod [3][3];
  logic [ABS_W-1:0]         p4_abs [3];
  logic [SQ_W-1:0]          p5_sq [3];
  logic [L1_W-1:0]          p5_l1;
  logic signed [SUM_W-1:0]  row_sum [3];
  logic signed [ABS_W-1:0]  row_t [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = SUM_W'(p3_prod[r][0]) + SUM_W'(p3_prod[r][1]) + SUM_W'(p3_prod[r][2]);
      // An arithmetic shift is the floor of the division by 4096.
      row_t[r]   = row_sum[r][SUM_W-1:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
      p5_vld <= 1'b0;
    end else begin
      p1_vld <= cmd.scan_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
      p5_vld <= p4_vld;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= cmd.scan_addr;
    p2_idx <= p1_idx;
    p3_idx <= p2_idx;
    p4_idx <= p3_idx;
    p5_idx <= p4_idx;
    p2_d[0] <= DIFF_W'(q[0]) - DIFF_W'(rd_data.x);
    p2_d[1] <= DIFF_W'(q[1]) - DIFF_W'(rd_data.y);
    p2_d[2] <= DIFF_W'(q[2]) - DIFF_W'(rd_data.z);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p3_prod[r][c] <= PROD_W'($signed(inv_row[r][16*c +: 16]) * p2_d[c]);
      end
      p4_abs[r] <= row_t[r][ABS_W-1] ? ABS_W'(-row_t[r]) : ABS_W'(row_t[r]);
      p5_sq[r]  <= SQ_W'(p4_abs[r] * p4_abs[r]);
    end
    p5_l1 <= L1_W'(p4_abs[0]) + L1_W'(p4_abs[1]) + L1_W'(p4_abs[2]);
  end

  // Square root, one result bit per stage. Stage 0 holds the sum of squares.
  logic              sq_vld [SQ_STAGES+1];
  logic [ADDR_W-1:0] sq_idx [SQ_STAGES+1];
  logic [L1_W-1:0]   sq_l1 [SQ_STAGES+1];
  logic [L2_W-1:0]   sq_v [SQ_STAGES+1];
  logic [REM_W-1:0]  sq_rem [SQ_STAGES+1];
  logic [ROOT_W-1:0] sq_root [SQ_STAGES+1];
  logic [REM_W-1:0]  rem_sh [SQ_STAGES];
  logic [REM_W-1:0]  trial [SQ_STAGES];

  always_comb begin
    for (int s = 0; s < SQ_STAGES; s++) begin
      rem_sh[s] = {sq_rem[s][REM_W-3:0], sq_v[s][L2_W-1 -: 2]};
      trial[s]  = {1'b0, sq_root[s], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= SQ_STAGES; s++) begin
        sq_vld[s] <= 1'b0;
      end
    end else begin
      sq_vld[0] <= p5_vld;
      for (int s = 0; s < SQ_STAGES; s++) begin
        sq_vld[s+1] <= sq_vld[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_idx[0]  <= p5_idx;
    sq_l1[0]   <= p5_l1;
    sq_v[0]    <= L2_W'(p5_sq[0]) + L2_W'(p5_sq[1]) + L2_W'(p5_sq[2]);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    for (int s = 0; s < SQ_STAGES; s++) begin
      sq_idx[s+1] <= sq_idx[s];
      sq_l1[s+1]  <= sq_l1[s];
      sq_v[s+1]   <= {sq_v[s][L2_W-3:0], 2'b00};
      if (rem_sh[s] >= trial[s]) begin
        sq_rem[s+1]  <= rem_sh[s] - trial[s];
        sq_root[s+1] <= {sq_root[s][ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem[s+1]  <= rem_sh[s];
        sq_root[s+1] <= {sq_root[s][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Sorted insertion: the slots holding a distance not above the new one form a prefix,
  // so their count is the insertion position and earlier points keep ties.
  logic [DIST_W-1:0]        new_dist;
  logic [MAX_NEIGHBORS-1:0] le;
  logic [FILL_W-1:0]        pos;
  logic                     ins;

  assign new_dist = norm_mode ? DIST_W'(sq_l1[SQ_STAGES]) : DIST_W'(sq_root[SQ_STAGES]);

  always_comb begin
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      le[i] = (FILL_W'(i) < fill) && (best_dist[i] <= new_dist);
    end
  end

  assign pos = FILL_W'($countones(le));
  assign ins = sq_vld[SQ_STAGES] && (pos < k);

  always_ff @(posedge clk) begin
    if (ins) begin
      for (int i = 1; i < MAX_NEIGHBORS; i++) begin
        if (FILL_W'(i) > pos && FILL_W'(i) < k) begin
          best_dist[i] <= best_dist[i-1];
          best_idx[i]  <= best_idx[i-1];
        end
      end
      best_dist[pos[SLOT_W-1:0]] <= new_dist;
      best_idx[pos[SLOT_W-1:0]]  <= sq_idx[SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.start) begin
      fill <= '0;
    end else if (ins && fill < k) begin
      fill <= fill + FILL_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld || cmd.load_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_point    <= rd_data;
      out_distance <= best_dist[cmd.emit_slot];
      out_empty    <= 1'b0;
      out_last     <= cmd.emit_last;
    end else if (cmd.load_empty) begin
      out_point    <= '0;
      out_distance <= '0;
      out_empty    <= 1'b1;
      out_last     <= 1'b1;
    end
  end

  logic sq_busy;
  always_comb begin
    sq_busy = 1'b0;
    for (int s = 0; s <= SQ_STAGES; s++) begin
      sq_busy = sq_busy | sq_vld[s];
    end
  end

  assign status.point_count = point_count;
  assign status.pipe_busy   = p1_vld | p2_vld | p3_vld | p4_vld | p5_vld | sq_busy;
  assign status.fill        = fill;
  assign status.out_free    = !out_valid || out_ready;

endmodule

### hw/rtl/linear_knn_search_transformed_metric_top.sv
// Clear and append are taken one per cycle while no query runs. A query over N stored
// points is accepted, scans them and drains the pipeline (one point per cycle through
// the five metric stages and the 24-stage square root), then reads each result from
// the store and loads it while the result side is ready. The next request waits until
// the last result is loaded. An empty store answers with one empty result. Reset empties
// the store, restores the identity transform and one neighbor; no clearing pass needed.
module linear_knn_search_transformed_metric_top (
  input logic          clk,
  input logic          rst,
  lknn_item_if.sink    item,
  lknn_result_if.source result,
  lknn_cfg_if.sink     cfg
);
  import lknn_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  point_t     out_point;

  assign cfg.ready = 1'b1;

  lknn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (item.kind),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lknn_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .coord_x      (item.coord_x),
    .coord_y      (item.coord_y),
    .coord_z      (item.coord_z),
    .payload_a    (item.payload_a),
    .payload_b    (item.payload_b),
    .payload_c    (item.payload_c),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .out_point    (out_point),
    .out_distance (result.distance),
    .out_empty    (result.empty_res),
    .out_last     (result.last)
  );

  assign result.near_x = out_point.x;
  assign result.near_y = out_point.y;
  assign result.near_z = out_point.z;
  assign result.near_a = out_point.a;
  assign result.near_b = out_point.b;
  assign result.near_c = out_point.c;

endmodule

### bench/lknn_tb_ifs.sv
// Testbench-side note: the channel interfaces come from the RTL file lknn_ifs.sv.
// This file holds the bench package with the expected-result record; depends on nothing.
package lknn_tb_pkg;
  typedef struct {
    logic signed [15:0] x, y, z, a, b, c;
    logic [25:0]        dist_val;
    logic               empty;
    logic               last;
  } neighbor_t;
endpackage

### bench/testbench.sv
// Self-checking bench for the transformed-metric k-nearest-neighbor search.
// Predicts every query answer in SystemVerilog and checks results in order;
// depends on lknn_pkg, lknn_ifs.sv and bench/lknn_tb_ifs.sv.
module testbench;
  import lknn_pkg::*;
  import lknn_tb_pkg::*;

  // Request kind that the block ignores.
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] x, y, z, a, b, c;
  } request_t;

  logic clk = 0;
  logic rst = 1;
  int   cycles = 0;
  int   errors = 0;

  lknn_item_if   item ();
  lknn_result_if result ();
  lknn_cfg_if    cfg ();

  linear_knn_search_transformed_metric_top dut (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg)
  );

  initial forever #1 clk = ~clk;

  // Predictor state.
  point_t      store_pts [MAX_POINTS];
  int          stored = 0;
  int          k_cfg = 1;
  logic        l1_mode = 0;
  logic [47:0] inv_rows [3] = '{48'd4096, 48'd4096 << 16, 48'd4096 << 32};

  request_t  pending_requests [$];
  neighbor_t expected_neighbors [$];
  bit        feeding = 0;
  bit        stimulus_done = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, lo, hi, mid;
    lo = 0;
    hi = 64'd4294967295;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    r = lo;
    return r;
  endfunction

  function automatic longint unsigned transformed_distance(int d [3]);
    longint unsigned l1, l2, mag, res;
    longint s, t;
    l1 = 0;
    l2 = 0;
    for (int r = 0; r < 3; r++) begin
      s = 0;
      for (int c = 0; c < 3; c++)
        s += longint'($signed(inv_rows[r][16*c +: 16])) * d[c];
      t = (s >= 0) ? s / 4096 : -((-s + 4095) / 4096);
      mag = (t < 0) ? -t : t;
      l1 += mag;
      l2 += mag * mag;
    end
    res = l1_mode ? l1 : root_floor(l2);
    return (res > 64'd67108863) ? 64'd67108863 : res;
  endfunction

  task automatic predict_query(request_t q);
    longint unsigned dists [$];
    int              idxs [$];
    longint unsigned dv;
    int              d [3];
    int              pos;
    neighbor_t       nb;
    if (stored == 0) begin
      nb = '{default: 0};
      nb.empty = 1;
      nb.last = 1;
      expected_neighbors.insert(expected_neighbors.size(), nb);
      return;
    end
    for (int n = 0; n < stored; n++) begin
      d[0] = q.x - store_pts[n].x;
      d[1] = q.y - store_pts[n].y;
      d[2] = q.z - store_pts[n].z;
      dv = transformed_distance(d);
      pos = 0;
      while (pos < dists.size() && dists[pos] <= dv) pos++;
      if (pos >= k_cfg) continue;
      dists.insert(pos, dv);
      idxs.insert(pos, n);
      if (dists.size() > k_cfg) begin
        void'(dists.pop_back());
        void'(idxs.pop_back());
      end
    end
    foreach (dists[i]) begin
      nb.x = store_pts[idxs[i]].x;
      nb.y = store_pts[idxs[i]].y;
      nb.z = store_pts[idxs[i]].z;
      nb.a = store_pts[idxs[i]].a;
      nb.b = store_pts[idxs[i]].b;
      nb.c = store_pts[idxs[i]].c;
      nb.dist_val = dists[i][25:0];
      nb.empty = 0;
      nb.last = (i == dists.size() - 1);
      expected_neighbors.insert(expected_neighbors.size(), nb);
    end
  endtask

  task automatic apply_request(request_t q);
    case (q.kind)
      KIND_CLEAR: stored = 0;
      KIND_APPEND: if (stored < MAX_POINTS) begin
        store_pts[stored] = '{c: q.c, b: q.b, a: q.a, z: q.z, y: q.y, x: q.x};
        stored++;
      end
      KIND_QUERY: predict_query(q);
      default: ;
    endcase
  endtask

  task automatic report(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      item.valid <= 0;
    end else if (item.valid && item.ready) begin
      apply_request(pending_requests.pop_front());
      if (feeding && pending_requests.size() > 0 && burst_left > 0) begin
        burst_left <= burst_left - 1;
        item.valid <= 1;
        {item.kind, item.coord_x, item.coord_y, item.coord_z} <=
          {pending_requests[0].kind, pending_requests[0].x, pending_requests[0].y,
           pending_requests[0].z};
        {item.payload_a, item.payload_b, item.payload_c} <=
          {pending_requests[0].a, pending_requests[0].b, pending_requests[0].c};
      end else begin
        item.valid <= 0;
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      end
    end else if (!item.valid && feeding && pending_requests.size() > 0) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else begin
        burst_left <= $urandom_range(0, 15);
        item.valid <= 1;
        {item.kind, item.coord_x, item.coord_y, item.coord_z} <=
          {pending_requests[0].kind, pending_requests[0].x, pending_requests[0].y,
           pending_requests[0].z};
        {item.payload_a, item.payload_b, item.payload_c} <=
          {pending_requests[0].a, pending_requests[0].b, pending_requests[0].c};
      end
    end
  end

  // Monitor with its own stall pattern on the result side.
  logic [7:0] stall_pattern = 8'hff;
  int         pattern_phase = 0;
  always @(posedge clk) begin
    neighbor_t want;
    if (rst) begin
      result.ready <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_neighbors.size() == 0) report("result with nothing expected");
        else begin
          want = expected_neighbors.pop_front();
          if (result.near_x !== want.x) report("near_x");
          if (result.near_y !== want.y) report("near_y");
          if (result.near_z !== want.z) report("near_z");
          if (result.near_a !== want.a) report("near_a");
          if (result.near_b !== want.b) report("near_b");
          if (result.near_c !== want.c) report("near_c");
          if (result.distance !== want.dist_val) report("distance");
          if (result.empty_res !== want.empty) report("empty_res");
          if (result.last !== want.last) report("last");
        end
      end
      pattern_phase <= (pattern_phase + 1) % 8;
      if (pattern_phase == 7 && $urandom_range(0, 3) == 0)
        stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      result.ready <= stall_pattern[pattern_phase];
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || item.valid || expected_neighbors.size() > 0)
      @(posedge clk);
    // Clears and appends give no result; let a trailing scan finish.
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
    // Leave the valid low for a cycle so that back-to-back writes never collide.
    @(posedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    case (idx)
      CFG_NEIGHBOR_COUNT: begin
        k_cfg = value[4:0];
        if (k_cfg == 0) k_cfg = 1;
        if (k_cfg > MAX_NEIGHBORS) k_cfg = MAX_NEIGHBORS;
      end
      CFG_NORM_MODE: l1_mode = value[0];
      CFG_INV_ROW0:  inv_rows[0] = value;
      CFG_INV_ROW1:  inv_rows[1] = value;
      CFG_INV_ROW2:  inv_rows[2] = value;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] coefficient();
    case ($urandom_range(0, 5))
      0: return 16'sd4096;
      1: return -16'sd4096;
      2: return 16'h7fff;
      3: return 16'h8000;
      4: return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] coordinate();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_request(logic [1:0] kind, logic signed [15:0] x, y, z, a, b, c);
    request_t q;
    q = '{kind: kind, x: x, y: y, z: z, a: a, b: b, c: c};
    pending_requests.insert(pending_requests.size(), q);
  endtask

  task automatic queue_random_set(int points, int queries);
    queue_request(KIND_CLEAR, coordinate(), coordinate(), coordinate(), 0, 0, 0);
    repeat (points) begin
      // Duplicates make ties between stored points.
      if ($urandom_range(0, 7) == 0 && points > 1)
        queue_request(KIND_APPEND, 16'sh0100, 16'sh0100, 16'sh0100,
                      16'($urandom), 16'($urandom), 16'($urandom));
      else
        queue_request(KIND_APPEND, coordinate(), coordinate(), coordinate(),
                      16'($urandom), 16'($urandom), 16'($urandom));
    end
    repeat (queries)
      queue_request(($urandom_range(0, 12) == 0) ? KIND_IGNORED : KIND_QUERY,
                    coordinate(), coordinate(), coordinate(), 16'($urandom),
                    16'($urandom), 16'($urandom));
  endtask

  initial begin
    item.valid = 0;
    item.kind = 0;
    item.coord_x = 0;
    item.coord_y = 0;
    item.coord_z = 0;
    item.payload_a = 0;
    item.payload_b = 0;
    item.payload_c = 0;
    result.ready = 0;
    cfg.valid = 0;
    cfg.index = 0;
    cfg.data = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty store, extremes, ties and an ignored kind.
    queue_request(KIND_QUERY, 0, 0, 0, 0, 0, 0);
    queue_request(KIND_APPEND, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, -1);
    queue_request(KIND_APPEND, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 0);
    queue_request(KIND_APPEND, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 2, 3);
    queue_request(KIND_QUERY, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0);
    queue_request(KIND_QUERY, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0);
    queue_request(KIND_IGNORED, 16'sh7fff, 16'sh7fff, 16'sh7fff, -1, -1, -1);
    queue_request(KIND_CLEAR, 0, 0, 0, 0, 0, 0);
    queue_request(KIND_QUERY, 1, 2, 3, 0, 0, 0);
    feeding = 1;
    wait_drained();

    write_register(CFG_NEIGHBOR_COUNT, 48'd16);
    write_register(CFG_NORM_MODE, 48'd1);
    queue_random_set(5, 3);
    wait_drained();

    // A neighbor count of zero answers with one neighbor.
    feeding = 0;
    write_register(CFG_NEIGHBOR_COUNT, 48'd0);
    queue_request(KIND_CLEAR, 0, 0, 0, 0, 0, 0);
    repeat (12)
      queue_request(KIND_APPEND, coordinate(), coordinate(), coordinate(),
                    16'($urandom), 16'($urandom), 16'($urandom));
    queue_request(KIND_QUERY, 0, 0, 0, 0, 0, 0);
    queue_request(KIND_QUERY, 16'sh7fff, 16'sh8000, 16'sh7fff, 0, 0, 0);
    feeding = 1;
    wait_drained();

    // Random phases over several settings, the extremes among them.
    for (int phase = 0; phase < 8; phase++) begin
      write_register(CFG_NEIGHBOR_COUNT, (phase == 1) ? 48'd31 : 48'($urandom_range(1, 16)));
      write_register(CFG_NORM_MODE, 48'(phase[0]));
      if (phase == 2) begin
        write_register(CFG_INV_ROW0, 48'hffff_ffff_ffff);
        write_register(CFG_INV_ROW1, 48'h8000_8000_8000);
        write_register(CFG_INV_ROW2, 48'h7fff_7fff_7fff);
      end else if (phase == 3) begin
        write_register(CFG_INV_ROW0, 48'd0);
        write_register(CFG_INV_ROW1, 48'd0);
        write_register(CFG_INV_ROW2, 48'd0);
      end else if (phase > 3) begin
        write_register(CFG_INV_ROW0, {coefficient(), coefficient(), coefficient()});
        write_register(CFG_INV_ROW1, {coefficient(), coefficient(), coefficient()});
        write_register(CFG_INV_ROW2, {coefficient(), coefficient(), coefficient()});
      end
      queue_random_set($urandom_range(1, 14), $urandom_range(2, 6));
      queue_random_set($urandom_range(0, 6), $urandom_range(1, 3));
      if (phase == 5) begin
        // Hold off the sender until every outstanding result is back.
        while (pending_requests.size() > 0 || item.valid) @(posedge clk);
        feeding = 0;
        while (expected_neighbors.size() > 0) @(posedge clk);
        queue_random_set(4, 2);
        feeding = 1;
      end
      wait_drained();
    end
    stimulus_done = 1;
  end

  always @(posedge clk) begin
    if (stimulus_done) begin
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
    end else if (cycles > 900000) begin
      $display("FAILURE");
      $finish;
    end
  end
endmodule
